// ===== design/assert_macros.svh =====
// assertion macros shared by the slice spacing median estimator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");
// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== design/ssme_pkg.sv =====
// types, constants and helpers of the slice spacing median estimator
`default_nettype none
package ssme_pkg;

   localparam int POS_W       = 32;
   localparam int NORM_W      = 16;
   localparam int PROD_W      = POS_W + NORM_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int RND_SHIFT   = 14;
   localparam int PROJ_W      = 34;
   localparam int DELTA_W     = 32;
   localparam int SLICE_CNT_W = 10;
   localparam logic [SLICE_CNT_W-1:0] SLICE_CNT_MAX = '1;
   localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(1) << (RND_SHIFT - 1);
   // dev * 1000 > 65536 holds exactly for dev >= 66
   localparam logic [DELTA_W-1:0] TOL_MIN_DEV = DELTA_W'(66);

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_NORMAL_X    = 2'd0,
      CSR_NORMAL_Y    = 2'd1,
      CSR_NORMAL_Z    = 2'd2,
      CSR_GEOMETRY_OK = 2'd3
   } csr_index_type;

   // series control sequencer
   typedef enum logic [5:0] {
      ST_RUN   = 6'b000001,
      ST_EVAL  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_MED   = 6'b001000,
      ST_CHECK = 6'b010000,
      ST_SEND  = 6'b100000
   } state_type;

   // one slice after projection and differencing
   typedef struct packed {
      logic               valid;
      logic               has_pos;
      logic               last;
      logic               nonzero;
      logic [DELTA_W-1:0] mag;
   } delta_beat_type;

   // command broadcast along the sorted chain
   typedef struct packed {
      logic               ins;
      logic               shift;
      logic [DELTA_W-1:0] din;
   } chain_ctrl_type;

   // true when dev breaks both max(1e-3 mm, 5% of median) bounds
   function automatic logic tol_exceeded(input logic [DELTA_W-1:0] dev,
                                         input logic [DELTA_W-1:0] med);
      logic [DELTA_W+4:0] dev20;
      dev20 = {1'b0, dev, 4'b0000} + {3'b000, dev, 2'b00};
      return (dev >= TOL_MIN_DEV) && (dev20 > {5'b00000, med});
   endfunction

endpackage
`default_nettype wire

// ===== design/ssme_if.sv =====
// valid/ready channel interfaces for slice beats and result beats
`default_nettype none
interface ssme_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ssme_pkg::POS_W-1:0]   pos_x;
   logic signed [ssme_pkg::POS_W-1:0]   pos_y;
   logic signed [ssme_pkg::POS_W-1:0]   pos_z;
   logic                                has_position;
   logic                                last_slice;

   modport source (output valid, pos_x, pos_y, pos_z, has_position, last_slice,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, has_position, last_slice,
                 output ready);
endinterface

interface ssme_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                spacing_valid;
   logic [ssme_pkg::DELTA_W-1:0]        spacing;
   logic                                nonuniform;

   modport source (output valid, spacing_valid, spacing, nonuniform, input ready);
   modport sink (input valid, spacing_valid, spacing, nonuniform, output ready);
endinterface
`default_nettype wire

// ===== design/ssme_cell.sv =====
// one cell of the sorted delta chain: insert-shift or read-out shift
`default_nettype none
module ssme_cell (
   input  logic                             clock,
   input  ssme_pkg::chain_ctrl_type         ctrl,
   input  logic                             occ,
   input  logic                             left_le,
   input  logic [ssme_pkg::DELTA_W-1:0]     left_val,
   input  logic [ssme_pkg::DELTA_W-1:0]     right_val,
   output logic [ssme_pkg::DELTA_W-1:0]     val,
   output logic                             le
);

   logic [ssme_pkg::DELTA_W-1:0] val_ff;
   logic [ssme_pkg::DELTA_W-1:0] val_in;

   // held value stays when it is not above the new delta
   assign le  = occ && (val_ff <= ctrl.din);
   assign val = val_ff;

   // take the new delta at the insert point, the left value past it
   always_comb begin
      val_in = val_ff;
      if (ctrl.ins && !le) begin
         val_in = left_le ? ctrl.din : left_val;
      end else if (ctrl.shift) begin
         val_in = right_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule
`default_nettype wire

// ===== design/ssme_chain.sv =====
// row of sorted cells, ascending from cell 0, read out at cell 0
`default_nettype none
module ssme_chain #(
   parameter int MAX_DELTAS = 256,
   parameter int CNT_W      = 9
) (
   input  logic                             clock,
   input  ssme_pkg::chain_ctrl_type         ctrl,
   input  logic [CNT_W-1:0]                 count,
   output logic [ssme_pkg::DELTA_W-1:0]     head
);

   logic [ssme_pkg::DELTA_W-1:0] val_w [MAX_DELTAS];
   logic                         le_w  [MAX_DELTAS];

   genvar i;
   generate
      for (i = 0; i < MAX_DELTAS; i++) begin : g_cell
         logic                         left_le;
         logic [ssme_pkg::DELTA_W-1:0] left_val;
         logic [ssme_pkg::DELTA_W-1:0] right_val;

         // neighbor wiring, ends tied off
         if (i == 0) begin : g_first
            assign left_le  = 1'b1;
            assign left_val = ctrl.din;
         end else begin : g_mid
            assign left_le  = le_w[i-1];
            assign left_val = val_w[i-1];
         end
         if (i == MAX_DELTAS - 1) begin : g_last
            assign right_val = val_w[i];
         end else begin : g_inner
            assign right_val = val_w[i+1];
         end

         ssme_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .occ       (count > CNT_W'(i)),
            .left_le   (left_le),
            .left_val  (left_val),
            .right_val (right_val),
            .val       (val_w[i]),
            .le        (le_w[i])
         );
      end
   endgenerate

   assign head = val_w[0];

endmodule
`default_nettype wire

// ===== design/ssme_proj.sv =====
// projection onto the normal and absolute delta to the previous slice
`default_nettype none
module ssme_proj (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic signed [ssme_pkg::POS_W-1:0]   pos_x,
   input  logic signed [ssme_pkg::POS_W-1:0]   pos_y,
   input  logic signed [ssme_pkg::POS_W-1:0]   pos_z,
   input  logic                                has_position,
   input  logic                                last_slice,
   input  logic signed [ssme_pkg::NORM_W-1:0]  normal_x,
   input  logic signed [ssme_pkg::NORM_W-1:0]  normal_y,
   input  logic signed [ssme_pkg::NORM_W-1:0]  normal_z,
   output ssme_pkg::delta_beat_type            beat
);

   localparam int PW = ssme_pkg::PROD_W;
   localparam int SW = ssme_pkg::SUM_W;
   localparam int JW = ssme_pkg::PROJ_W;
   localparam int DW = ssme_pkg::DELTA_W;
   localparam int QW = SW - ssme_pkg::RND_SHIFT;

   // stage 1: three products
   logic signed [PW-1:0] px_in, py_in, pz_in;
   logic signed [PW-1:0] px_ff, py_ff, pz_ff;
   logic                 v1_ff, hp1_ff, last1_ff;

   assign px_in = pos_x * normal_x;
   assign py_in = pos_y * normal_y;
   assign pz_in = pos_z * normal_z;

   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      pz_ff    <= pz_in;
      hp1_ff   <= has_position;
      last1_ff <= last_slice;
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   // stage 2: sum, round half up, saturate to the projection range
   logic [SW-1:0] sum_w;
   logic [QW-1:0] quo_w;
   logic [JW-1:0] proj_in;
   logic [JW-1:0] proj_ff;
   logic          v2_ff, hp2_ff, last2_ff;

   assign sum_w = SW'(px_ff) + SW'(py_ff) + SW'(pz_ff) + ssme_pkg::RND_HALF;
   assign quo_w = sum_w[SW-1:ssme_pkg::RND_SHIFT];

   always_comb begin
      if (&quo_w[QW-1:JW-1] || ~|quo_w[QW-1:JW-1]) begin
         proj_in = quo_w[JW-1:0];
      end else if (quo_w[QW-1]) begin
         proj_in = {1'b1, {(JW-1){1'b0}}};
      end else begin
         proj_in = {1'b0, {(JW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      proj_ff  <= proj_in;
      hp2_ff   <= hp1_ff;
      last2_ff <= last1_ff;
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   // stage 3: delta to the previous projection, saturated magnitude
   logic [JW-1:0] prev_ff, prev_in;
   logic          seen_ff, seen_in;
   logic [JW:0]   diff_w;
   logic [JW:0]   abs_w;
   logic [DW-1:0] mag_w;
   ssme_pkg::delta_beat_type beat_ff, beat_in;

   assign diff_w = {proj_ff[JW-1], proj_ff} - {prev_ff[JW-1], prev_ff};
   assign abs_w  = diff_w[JW] ? (~diff_w + 1'b1) : diff_w;
   assign mag_w  = (|abs_w[JW:DW]) ? {DW{1'b1}} : abs_w[DW-1:0];

   always_comb begin
      prev_in         = prev_ff;
      seen_in         = seen_ff;
      beat_in.valid   = v2_ff;
      beat_in.has_pos = hp2_ff;
      beat_in.last    = last2_ff;
      beat_in.nonzero = seen_ff && (mag_w != '0);
      beat_in.mag     = mag_w;
      if (v2_ff) begin
         if (hp2_ff) begin
            prev_in = proj_ff;
         end
         seen_in = 1'b1;
         // series end returns to a fresh start
         if (last2_ff) begin
            prev_in = '0;
            seen_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         seen_ff <= 1'b0;
         beat_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         seen_ff <= seen_in;
         beat_ff <= beat_in;
      end
   end

   assign beat = beat_ff;

endmodule
`default_nettype wire

// ===== design/slice_spacing_median_estimator.sv =====
// top level: slice stream in, median slice spacing per series out
//
//   channel   dir   beat contents                                   accepted when
//   req_ch    in    pos_x/pos_y/pos_z, has_position, last_slice     valid && ready
//   rsp_ch    out   spacing_valid, spacing, nonuniform              valid && ready
//   csr_*     in    csr_index selects normal_x/y/z or geometry_ok   csr_we
//
// Slices enter one per cycle while req_ch is ready, through a four stage pipe
// (multiply, round, delta, sorted insert); each delta is put into its sorted
// place in the cell chain. After the last slice, input is held off until the
// result is taken on rsp_ch: unless the result is invalid, the chain is shifted
// out through cell 0 up to the median, then the median and the tolerance test
// are each worked out in a state of their own.
// Synchronous active-high reset; the sorted chain needs no clearing pass.
`include "assert_macros.svh"
`default_nettype none
module slice_spacing_median_estimator #(
   parameter int MAX_DELTAS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   ssme_req_if.sink                            req_ch,
   ssme_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [ssme_pkg::NORM_W-1:0]         csr_wdata
);

   localparam int CNT_W = $clog2(MAX_DELTAS + 1);
   localparam int DW    = ssme_pkg::DELTA_W;
   localparam int NW    = ssme_pkg::NORM_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_DELTAS);

   // configuration registers
   logic signed [NW-1:0] normal_x_ff, normal_y_ff, normal_z_ff;
   logic                 geometry_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_x_ff    <= '0;
         normal_y_ff    <= '0;
         normal_z_ff    <= '0;
         geometry_ok_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (ssme_pkg::csr_index_type'(csr_index))
            ssme_pkg::CSR_NORMAL_X:    normal_x_ff    <= csr_wdata;
            ssme_pkg::CSR_NORMAL_Y:    normal_y_ff    <= csr_wdata;
            ssme_pkg::CSR_NORMAL_Z:    normal_z_ff    <= csr_wdata;
            ssme_pkg::CSR_GEOMETRY_OK: geometry_ok_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // input handshake: closed from the last slice until its result is taken
   logic busy_ff, busy_in;
   logic req_acc;
   logic rsp_acc;

   assign req_ch.ready = !busy_ff;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_acc      = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      busy_in = busy_ff;
      if (rsp_acc) begin
         busy_in = 1'b0;
      end else if (req_acc && req_ch.last_slice) begin
         busy_in = 1'b1;
      end
   end

   // projection and delta pipe
   ssme_pkg::delta_beat_type beat;

   ssme_proj u_proj (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_acc),
      .pos_x        (req_ch.pos_x),
      .pos_y        (req_ch.pos_y),
      .pos_z        (req_ch.pos_z),
      .has_position (req_ch.has_position),
      .last_slice   (req_ch.last_slice),
      .normal_x     (normal_x_ff),
      .normal_y     (normal_y_ff),
      .normal_z     (normal_z_ff),
      .beat         (beat)
   );

   // sorted chain
   ssme_pkg::chain_ctrl_type ctrl;
   logic [DW-1:0]            head;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   ssme_chain #(
      .MAX_DELTAS (MAX_DELTAS),
      .CNT_W      (CNT_W)
   ) u_chain (
      .clock (clock),
      .ctrl  (ctrl),
      .count (cnt_ff),
      .head  (head)
   );

   // series state and result sequencer
   ssme_pkg::state_type                  state_ff, state_in;
   logic                                 failed_ff, failed_in;
   logic [ssme_pkg::SLICE_CNT_W-1:0]     slc_ff, slc_in;
   logic [DW-1:0]                        hi_ff, hi_in;
   logic [DW-1:0]                        lo_ff, lo_in;
   logic [DW-1:0]                        mid_a_ff, mid_a_in;
   logic [DW-1:0]                        mid_b_ff, mid_b_in;
   logic [DW-1:0]                        med_ff, med_in;
   logic [CNT_W-1:0]                     rd_ff, rd_in;
   logic [CNT_W-1:0]                     mid;
   logic                                 even;
   logic [DW:0]                          pair_sum;
   logic                                 res_valid_ff, res_valid_in;
   logic [DW-1:0]                        res_spacing_ff, res_spacing_in;
   logic                                 res_nonuni_ff, res_nonuni_in;

   assign mid      = cnt_ff >> 1;
   assign even     = !cnt_ff[0];
   assign pair_sum = {1'b0, mid_a_ff} + {1'b0, mid_b_ff};

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      failed_in      = failed_ff;
      slc_in         = slc_ff;
      hi_in          = hi_ff;
      lo_in          = lo_ff;
      mid_a_in       = mid_a_ff;
      mid_b_in       = mid_b_ff;
      med_in         = med_ff;
      rd_in          = rd_ff;
      res_valid_in   = res_valid_ff;
      res_spacing_in = res_spacing_ff;
      res_nonuni_in  = res_nonuni_ff;
      ctrl.ins       = 1'b0;
      ctrl.shift     = 1'b0;
      ctrl.din       = beat.mag;

      unique case (state_ff)
         ssme_pkg::ST_RUN: begin
            // fold one slice into the series
            if (beat.valid) begin
               if (!beat.has_pos) begin
                  failed_in = 1'b1;
               end else if (beat.nonzero && !failed_ff) begin
                  if (cnt_ff == CNT_FULL) begin
                     failed_in = 1'b1;
                  end else begin
                     ctrl.ins = 1'b1;
                     cnt_in   = cnt_ff + 1'b1;
                     if (beat.mag > hi_ff) begin
                        hi_in = beat.mag;
                     end
                  end
               end
               if (slc_ff != ssme_pkg::SLICE_CNT_MAX) begin
                  slc_in = slc_ff + 1'b1;
               end
               if (beat.last) begin
                  state_in = ssme_pkg::ST_EVAL;
               end
            end
         end
         ssme_pkg::ST_EVAL: begin
            rd_in = '0;
            if (geometry_ok_ff && !failed_ff && (slc_ff >= 2) && (cnt_ff != '0)) begin
               state_in = ssme_pkg::ST_READ;
            end else begin
               res_valid_in   = 1'b0;
               res_spacing_in = '0;
               res_nonuni_in  = 1'b0;
               state_in       = ssme_pkg::ST_SEND;
            end
         end
         ssme_pkg::ST_READ: begin
            // walk the chain down to the median entries
            ctrl.shift = 1'b1;
            if (rd_ff == '0) begin
               lo_in = head;
            end
            if (even && (rd_ff == mid - 1'b1)) begin
               mid_a_in = head;
            end
            if (rd_ff == mid) begin
               mid_b_in = head;
               state_in = ssme_pkg::ST_MED;
            end else begin
               rd_in = rd_ff + 1'b1;
            end
         end
         ssme_pkg::ST_MED: begin
            med_in   = even ? pair_sum[DW:1] : mid_b_ff;
            state_in = ssme_pkg::ST_CHECK;
         end
         ssme_pkg::ST_CHECK: begin
            // largest deviations sit at the two ends of the sorted set
            res_valid_in   = 1'b1;
            res_spacing_in = med_ff;
            res_nonuni_in  = ssme_pkg::tol_exceeded(med_ff - lo_ff, med_ff) ||
                             ssme_pkg::tol_exceeded(hi_ff - med_ff, med_ff);
            state_in       = ssme_pkg::ST_SEND;
         end
         ssme_pkg::ST_SEND: begin
            if (rsp_acc) begin
               cnt_in    = '0;
               failed_in = 1'b0;
               slc_in    = '0;
               hi_in     = '0;
               state_in  = ssme_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = ssme_pkg::ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lo_ff          <= lo_in;
      mid_a_ff       <= mid_a_in;
      mid_b_ff       <= mid_b_in;
      med_ff         <= med_in;
      res_valid_ff   <= res_valid_in;
      res_spacing_ff <= res_spacing_in;
      res_nonuni_ff  <= res_nonuni_in;
      if (reset) begin
         state_ff  <= ssme_pkg::ST_RUN;
         busy_ff   <= 1'b0;
         cnt_ff    <= '0;
         failed_ff <= 1'b0;
         slc_ff    <= '0;
         hi_ff     <= '0;
         rd_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         cnt_ff    <= cnt_in;
         failed_ff <= failed_in;
         slc_ff    <= slc_in;
         hi_ff     <= hi_in;
         rd_ff     <= rd_in;
      end
   end

   // result beat
   assign rsp_ch.valid         = (state_ff == ssme_pkg::ST_SEND);
   assign rsp_ch.spacing_valid = res_valid_ff;
   assign rsp_ch.spacing       = res_spacing_ff;
   assign rsp_ch.nonuniform    = res_nonuni_ff;

   // checks
   `ASSERT_NEVER(a_cnt_bound, clock, reset, cnt_ff > CNT_FULL)
   `ASSERT_ALWAYS(a_read_bound, clock, reset,
      (state_ff == ssme_pkg::ST_READ) |-> (rd_ff <= mid))
   `ASSERT_ALWAYS(a_invalid_zero, clock, reset,
      (rsp_ch.valid && !rsp_ch.spacing_valid) |->
         (rsp_ch.spacing == '0 && !rsp_ch.nonuniform))
   `ASSERT_ALWAYS(a_series_cleared, clock, reset,
      rsp_acc |=> (cnt_ff == '0 && !failed_ff && req_ch.ready))

endmodule
`default_nettype wire
